/* src/u8r_pkg.sv */
// ----------------------------------------------------------------------------
// u8r_pkg
// Shared types and constants for the UTF-8 repair stream: item formats,
// sequence tracking state and output queue sizing.
// ----------------------------------------------------------------------------
package u8r_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  pend_count;
        logic [2:0]  exp_len;
        logic [20:0] acc;
    } seq_state_t;

    localparam logic [7:0]  REPL_RESET = 8'h5F;

    localparam logic [2:0]  LEN2 = 3'd2;
    localparam logic [2:0]  LEN3 = 3'd3;
    localparam logic [2:0]  LEN4 = 3'd4;

    localparam logic [20:0] MIN_LEN2   = 21'h00080;
    localparam logic [20:0] MIN_LEN3   = 21'h00800;
    localparam logic [20:0] MIN_LEN4   = 21'h10000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST = 21'h0D800;
    localparam logic [20:0] SURR_LAST  = 21'h0DFFF;

    localparam int MAX_RES   = 4;
    localparam int RES_CNT_W = 3;
    localparam int PEND_DEPTH = 3;

    localparam int QDEPTH      = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;
    localparam int QSTALL_LEVEL = QDEPTH - MAX_RES;

endpackage

/* src/u8r_step.sv */
// ----------------------------------------------------------------------------
// u8r_step
// Next-state and result logic for one input byte: sequence buffering,
// validation of complete sequences, replacement of bad bytes and flushing at
// the end of a string.
// ----------------------------------------------------------------------------
module u8r_step
(
    input  u8r_pkg::in_item_t   item,
    input  logic [7:0]          repl,
    input  u8r_pkg::seq_state_t cur_state,
    input  logic [7:0]          cur_pend [u8r_pkg::PEND_DEPTH],
    output u8r_pkg::seq_state_t next_state,
    output logic [7:0]          next_pend [u8r_pkg::PEND_DEPTH],
    output logic [u8r_pkg::RES_CNT_W-1:0] res_count,
    output u8r_pkg::out_item_t  res_items [u8r_pkg::MAX_RES]
);

    logic [7:0]                    b;
    logic [20:0]                   cp;
    logic [20:0]                   minimum;
    logic                          cp_bad;
    logic                          do_fresh;
    logic [u8r_pkg::RES_CNT_W-1:0] n;
    logic [7:0]                    res_buf [u8r_pkg::MAX_RES];
    u8r_pkg::seq_state_t           s;

    assign b  = item.in_byte;
    assign cp = {cur_state.acc[14:0], b[5:0]};

    always_comb
    begin
        case (cur_state.exp_len)
            u8r_pkg::LEN2: minimum = u8r_pkg::MIN_LEN2;
            u8r_pkg::LEN3: minimum = u8r_pkg::MIN_LEN3;
            default:       minimum = u8r_pkg::MIN_LEN4;
        endcase
        cp_bad = (cp < minimum) || (cp > u8r_pkg::CP_MAX) ||
                 ((cp >= u8r_pkg::SURR_FIRST) && (cp <= u8r_pkg::SURR_LAST));
    end

    always_comb
    begin
        n         = '0;
        s         = cur_state;
        next_pend = cur_pend;
        do_fresh  = 1'b0;
        for (int k = 0; k < u8r_pkg::MAX_RES; k++)
        begin
            res_buf[k] = repl;
        end

        if (cur_state.pend_count != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                if (({1'b0, s.pend_count} + 3'd1) < s.exp_len)
                begin
                    if (s.pend_count < 2'd3)
                    begin
                        next_pend[s.pend_count] = b;
                    end
                    s.pend_count = s.pend_count + 2'd1;
                    s.acc        = cp;
                end
                else
                begin
                    if (cp_bad)
                    begin
                        res_buf[n[1:0]] = repl;
                        n = n + 3'd1;
                    end
                    else
                    begin
                        for (int k = 0; k < u8r_pkg::PEND_DEPTH; k++)
                        begin
                            if (2'(k) < s.pend_count)
                            begin
                                res_buf[n[1:0]] = cur_pend[k];
                                n = n + 3'd1;
                            end
                        end
                        if (n < 3'(u8r_pkg::MAX_RES))
                        begin
                            res_buf[n[1:0]] = b;
                            n = n + 3'd1;
                        end
                    end
                    s = '0;
                end
            end
            else
            begin
                for (int k = 0; k < u8r_pkg::PEND_DEPTH; k++)
                begin
                    if (2'(k) < s.pend_count)
                    begin
                        res_buf[n[1:0]] = repl;
                        n = n + 3'd1;
                    end
                end
                s        = '0;
                do_fresh = 1'b1;
            end
        end
        else
        begin
            do_fresh = 1'b1;
        end

        if (do_fresh)
        begin
            if (b[7] == 1'b0)
            begin
                res_buf[n[1:0]] = b;
                n = n + 3'd1;
            end
            else if (b[7:5] == 3'b110)
            begin
                next_pend[0] = b;
                s.pend_count = 2'd1;
                s.exp_len    = u8r_pkg::LEN2;
                s.acc        = {16'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                next_pend[0] = b;
                s.pend_count = 2'd1;
                s.exp_len    = u8r_pkg::LEN3;
                s.acc        = {17'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                next_pend[0] = b;
                s.pend_count = 2'd1;
                s.exp_len    = u8r_pkg::LEN4;
                s.acc        = {18'd0, b[2:0]};
            end
            else
            begin
                res_buf[n[1:0]] = repl;
                n = n + 3'd1;
            end
        end

        if (item.string_last)
        begin
            for (int k = 0; k < u8r_pkg::PEND_DEPTH; k++)
            begin
                if ((2'(k) < s.pend_count) && (n < 3'(u8r_pkg::MAX_RES)))
                begin
                    res_buf[n[1:0]] = repl;
                    n = n + 3'd1;
                end
            end
            s = '0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < u8r_pkg::MAX_RES; k++)
        begin
            res_items[k].out_byte   = res_buf[k];
            res_items[k].run_last   = ((3'(k) + 3'd1) == n);
            res_items[k].string_end = ((3'(k) + 3'd1) == n) && item.string_last;
        end
    end

    assign next_state = s;
    assign res_count  = n;

endmodule

/* src/u8r_queue.sv */
// ----------------------------------------------------------------------------
// u8r_queue
// Output queue that takes up to four result items in one cycle and hands
// them out one per cycle while out_stall is low. It asks the input side to
// hold off while fewer than four entries are free.
// ----------------------------------------------------------------------------
module u8r_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [u8r_pkg::RES_CNT_W-1:0] push_count,
    input  u8r_pkg::out_item_t            push_items [u8r_pkg::MAX_RES],
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output u8r_pkg::out_item_t            out_item
);

    u8r_pkg::out_item_t           q_mem [u8r_pkg::QDEPTH];
    logic [u8r_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [u8r_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [u8r_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [u8r_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [u8r_pkg::QCNT_W-1:0]   count_reg;
    logic [u8r_pkg::QCNT_W-1:0]   count_next;
    logic                         pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_item  = q_mem[rd_ptr_reg];
    assign busy      = (count_reg > u8r_pkg::QCNT_W'(u8r_pkg::QSTALL_LEVEL));

    assign wr_ptr_next = wr_ptr_reg + u8r_pkg::QPTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + u8r_pkg::QPTR_W'(pop);
    assign count_next  = count_reg + u8r_pkg::QCNT_W'(push_count)
                         - u8r_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < u8r_pkg::MAX_RES; i++)
        begin
            if (u8r_pkg::RES_CNT_W'(i) < push_count)
            begin
                q_mem[wr_ptr_reg + u8r_pkg::QPTR_W'(i)] <= push_items[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/utf8_repair_stream.sv */
// ----------------------------------------------------------------------------
// utf8_repair_stream
// Streaming UTF-8 repair: passes well-formed sequences through and replaces
// bad lead bytes, stray continuations, broken and forbidden sequences.
// ----------------------------------------------------------------------------
// The input channel carries one raw byte per item with a flag on the last
// byte of a string. The output channel carries repaired bytes, each marked
// when it is the last result of its input item and when it ends the string.
// An input item may cause zero to four result items; the bytes of an open
// multi-byte sequence appear together once the sequence completes.
// The block accepts one input item per cycle while in_stall is low. Its
// results are written into an eight-entry output queue at the accepting
// edge, so out_valid is high in the next cycle; the queue drains one item
// per cycle while out_stall is low. Input stall rises while fewer than four
// queue entries are free; since a string never yields more bytes than it
// consumed, it stays low while the receiver keeps up. A stalled receiver
// holds the head item in place. The replacement byte is to be written over
// the configuration port while the block is idle; the block does not enforce
// this. Reset empties the queue, closes any open sequence and sets the replacement byte to underscore.
// ----------------------------------------------------------------------------
module utf8_repair_stream
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  u8r_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output u8r_pkg::out_item_t  out_item,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    logic                          in_accept;
    logic                          queue_busy;
    logic [7:0]                    repl_reg;
    u8r_pkg::seq_state_t           seq_reg;
    u8r_pkg::seq_state_t           seq_next;
    logic [7:0]                    pend_reg  [u8r_pkg::PEND_DEPTH];
    logic [7:0]                    pend_next [u8r_pkg::PEND_DEPTH];
    logic [u8r_pkg::RES_CNT_W-1:0] res_count;
    logic [u8r_pkg::RES_CNT_W-1:0] push_count;
    u8r_pkg::out_item_t            res_items [u8r_pkg::MAX_RES];

    assign in_stall   = queue_busy;
    assign in_accept  = in_valid && !in_stall;
    assign push_count = in_accept ? res_count : '0;

    u8r_step u_step
    (
        .item       (in_item),
        .repl       (repl_reg),
        .cur_state  (seq_reg),
        .cur_pend   (pend_reg),
        .next_state (seq_next),
        .next_pend  (pend_next),
        .res_count  (res_count),
        .res_items  (res_items)
    );

    u8r_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_items (res_items),
        .busy       (queue_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= u8r_pkg::REPL_RESET;
            seq_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                repl_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                seq_reg <= seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_reg <= pend_next;
        end
    end

    // A string's last byte always yields at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_item.string_last) |-> (res_count != '0))
    else $error("last byte of a string produced no result");

    // An open sequence has buffered fewer bytes than its length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg.pend_count != 2'd0) |->
            (({1'b0, seq_reg.pend_count} < seq_reg.exp_len) &&
             ((seq_reg.exp_len == u8r_pkg::LEN2) ||
              (seq_reg.exp_len == u8r_pkg::LEN3) ||
              (seq_reg.exp_len == u8r_pkg::LEN4))))
    else $error("inconsistent open sequence state");

    // After an accepted item with results, out_valid is high on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (res_count != '0)) |=> out_valid)
    else $error("results were not queued");

    // Nothing is pushed while the queue holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_busy |-> (push_count == '0))
    else $error("push while queue lacks room");

endmodule

/* test/utf8_repair_stream_tb.sv */
// ----------------------------------------------------------------------------
// utf8_repair_stream_tb
// Drives byte strings into the UTF-8 repair stream and checks every repaired
// item against a predictor that tracks open sequences on its own. A short
// directed set covers pass-through, forbidden and broken sequences. Random
// strings of valid, raw, truncated and stray bytes follow under three
// replacement settings, with random idling on both sides, a calm stretch
// and one long receiver hold that backs up the block's output queue.
// ----------------------------------------------------------------------------
module utf8_repair_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT      = 30;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 80;
    localparam int CALM_FROM     = 150;
    localparam int CALM_TO       = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [8:0] DIRECTED [25] = '{
        {8'h00, 1'b0}, {8'h7F, 1'b0},
        {8'hC3, 1'b0}, {8'hA9, 1'b0},
        {8'hF4, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
        {8'h80, 1'b0},
        {8'hFF, 1'b0},
        {8'hC0, 1'b0}, {8'h80, 1'b0},
        {8'hED, 1'b0}, {8'hA0, 1'b0}, {8'h80, 1'b0},
        {8'hF4, 1'b0}, {8'h90, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b0},
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'h41, 1'b1},
        {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b1}
    };

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    u8r_pkg::in_item_t   in_item     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    u8r_pkg::out_item_t  out_item;
    logic                cfg_wr_en   = 1'b0;
    logic [7:0]          cfg_wr_data = '0;

    u8r_pkg::in_item_t  send_q[$];
    u8r_pkg::out_item_t repaired_q[$];
    int                 accepted_cnt = 0;
    int                 fail_cnt     = 0;
    int                 hold_left    = 0;
    bit                 hold_done    = 1'b0;

    logic [7:0]  repl_byte = u8r_pkg::REPL_RESET;
    logic [7:0]  seq_bytes [u8r_pkg::PEND_DEPTH];
    logic [1:0]  seq_count = '0;
    logic [2:0]  seq_len   = '0;
    logic [20:0] seq_cp    = '0;
    logic [7:0]  step_out[$];

    utf8_repair_stream dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit idling_allowed();
        return !(accepted_cnt >= CALM_FROM && accepted_cnt < CALM_TO) && hold_left == 0;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        if (step_out.size() < u8r_pkg::MAX_RES)
            step_out.insert(step_out.size(), b);
    endfunction

    function automatic void flush_open_seq();
        for (int k = 0; k < seq_count; k++)
            emit_byte(repl_byte);
        seq_count = '0;
        seq_len   = '0;
        seq_cp    = '0;
    endfunction

    task automatic predict_repair(u8r_pkg::in_item_t it);
        logic [7:0]         b;
        logic [20:0]        cp;
        logic [20:0]        floor_cp;
        u8r_pkg::out_item_t r;
        b = it.in_byte;
        step_out.delete();
        if (seq_count != 0 && b[7:6] == 2'b10)
        begin
            cp = {seq_cp[14:0], b[5:0]};
            if (3'(seq_count) + 3'd1 < seq_len)
            begin
                seq_bytes[seq_count] = b;
                seq_count++;
                seq_cp = cp;
            end
            else
            begin
                floor_cp = (seq_len == u8r_pkg::LEN2) ? u8r_pkg::MIN_LEN2 :
                           (seq_len == u8r_pkg::LEN3) ? u8r_pkg::MIN_LEN3 :
                                                        u8r_pkg::MIN_LEN4;
                if (cp < floor_cp || cp > u8r_pkg::CP_MAX ||
                    (cp >= u8r_pkg::SURR_FIRST && cp <= u8r_pkg::SURR_LAST))
                    emit_byte(repl_byte);
                else
                begin
                    for (int k = 0; k < seq_count; k++)
                        emit_byte(seq_bytes[k]);
                    emit_byte(b);
                end
                seq_count = '0;
                seq_len   = '0;
                seq_cp    = '0;
            end
        end
        else
        begin
            flush_open_seq();
            if (b[7] == 1'b0)
                emit_byte(b);
            else
            begin
                if (b[7:5] == 3'b110)
                begin
                    seq_len = u8r_pkg::LEN2;
                    seq_cp  = 21'(b[4:0]);
                end
                else if (b[7:4] == 4'b1110)
                begin
                    seq_len = u8r_pkg::LEN3;
                    seq_cp  = 21'(b[3:0]);
                end
                else if (b[7:3] == 5'b11110)
                begin
                    seq_len = u8r_pkg::LEN4;
                    seq_cp  = 21'(b[2:0]);
                end
                if (seq_len == '0)
                    emit_byte(repl_byte);
                else
                begin
                    seq_bytes[0] = b;
                    seq_count    = 2'd1;
                end
            end
        end
        if (it.string_last)
            flush_open_seq();
        foreach (step_out[k])
        begin
            r.out_byte   = step_out[k];
            r.run_last   = (k == step_out.size() - 1);
            r.string_end = (k == step_out.size() - 1) && it.string_last;
            repaired_q.insert(repaired_q.size(), r);
        end
    endtask

    task automatic report_failure(string what, u8r_pkg::out_item_t want,
                                  u8r_pkg::out_item_t got);
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT)
            $display({"%0t: %0s: expected byte %02h run_last %0b string_end %0b, ",
                      "got byte %02h run_last %0b string_end %0b"},
                     $realtime, what, want.out_byte, want.run_last, want.string_end,
                     got.out_byte, got.run_last, got.string_end);
    endtask

    // Pushes the lead byte of a sequence of the given length and the first
    // keep continuation bytes of the code point.
    function automatic void push_utf8(ref logic [7:0] txt[$], input int cp, input int len,
                                      input int keep);
        logic [7:0] lead;
        lead = (len == 2) ? 8'hC0 : (len == 3) ? 8'hE0 : 8'hF0;
        txt.insert(txt.size(), lead | 8'(cp >> (6 * (len - 1))));
        for (int k = len - 2; k >= len - 1 - keep; k--)
            txt.insert(txt.size(), 8'h80 | 8'((cp >> (6 * k)) & 'h3F));
    endfunction

    task automatic queue_random_text(int n_items);
        logic [7:0]        txt[$];
        u8r_pkg::in_item_t it;
        int                count;
        int                len;
        int                cp;
        count = 0;
        while (count < n_items)
        begin
            txt.delete();
            repeat ($urandom_range(1, 8))
            begin
                len = $urandom_range(2, 4);
                case ($urandom_range(0, 9))
                    0, 1: txt.insert(txt.size(), 8'($urandom_range(0, 127)));
                    2, 3, 4:
                    begin
                        cp = (len == 2) ? $urandom_range('h80, 'h7FF) :
                             (len == 3) ? $urandom_range('h800, 'hFFFF) :
                                          $urandom_range('h10000, 'h10FFFF);
                        push_utf8(txt, cp, len, len - 1);
                    end
                    5, 6:
                    begin
                        txt.insert(txt.size(), 8'($urandom_range('hC0, 'hF7)));
                        repeat (len - 1)
                            txt.insert(txt.size(), 8'($urandom_range('h80, 'hBF)));
                    end
                    7:
                    begin
                        cp = $urandom() & ((1 << (5 * len + 1)) - 1);
                        push_utf8(txt, cp, len, $urandom_range(0, len - 2));
                    end
                    8: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
                    default: txt.insert(txt.size(), 8'($urandom_range('h80, 'hBF)));
                endcase
            end
            foreach (txt[k])
            begin
                it.in_byte     = txt[k];
                it.string_last = (k == txt.size() - 1);
                send_q.insert(send_q.size(), it);
            end
            count += txt.size();
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((send_q.size() != 0 || in_valid || repaired_q.size() != 0)
               && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_repl(logic [7:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        repl_byte = value;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_repair(in_item);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_q.size() != 0 && !(idling_allowed() && $urandom_range(0, 99) < IDLE_PCT))
                begin
                    in_item  <= send_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        u8r_pkg::out_item_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (repaired_q.size() == 0)
                    report_failure("unexpected item", '0, out_item);
                else
                begin
                    want = repaired_q.pop_front();
                    if (out_item.out_byte !== want.out_byte || out_item.run_last !== want.run_last
                        || out_item.string_end !== want.string_end)
                        report_failure("mismatch", want, out_item);
                end
            end
            out_stall <= (hold_left != 0) || (idling_allowed() && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        #200_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED[k])
            send_q.insert(send_q.size(), u8r_pkg::in_item_t'(DIRECTED[k]));
        wait_drained();
        write_repl(8'h00);
        queue_random_text(60);
        wait_drained();
        write_repl(8'hFF);
        queue_random_text(60);
        wait_drained();
        write_repl(8'($urandom_range(0, 255)));
        queue_random_text(60);
        wait_drained();
        if (fail_cnt == 0 && repaired_q.size() == 0 && send_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* utf8_repair_stream.f */
src/u8r_pkg.sv
src/u8r_step.sv
src/u8r_queue.sv
src/utf8_repair_stream.sv
test/utf8_repair_stream_tb.sv
